// ----- rtl/identifier_symbol_table_scanner_top_macros.svh -----
// assertion macros for the identifier symbol table scanner
// used by the front and table modules; no other dependencies
`ifndef IDENTIFIER_SYMBOL_TABLE_SCANNER_TOP_MACROS_SVH
`define IDENTIFIER_SYMBOL_TABLE_SCANNER_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define ISTS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ists check failed");

// next-cycle implication outside reset
`define ISTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ists check failed");

`endif

// ----- rtl/ists_pkg.sv -----
// package for the identifier symbol table scanner
// types, character codes and word tables; no dependencies
package ists_pkg;

   localparam int MaxChars = 32;
   localparam logic [4:0] NoType = 5'd21;
   localparam int KeyCount = 21;
   localparam int IgnCount = 5;

   localparam logic [2:0] EV_KEYWORD = 3'd0;
   localparam logic [2:0] EV_IGNORED = 3'd1;
   localparam logic [2:0] EV_INSERT  = 3'd2;
   localparam logic [2:0] EV_REDECL  = 3'd3;
   localparam logic [2:0] EV_MULTI   = 3'd4;
   localparam logic [2:0] EV_UNDECL  = 3'd5;
   localparam logic [2:0] EV_USE     = 3'd6;
   localparam logic [2:0] EV_FULL    = 3'd7;

   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_USCORE = 8'h5f;

   localparam logic [1:0] SKIP_NONE  = 2'd0;
   localparam logic [1:0] SKIP_QUOTE = 2'd1;
   localparam logic [1:0] SKIP_ANGLE = 2'd2;

   // finished token handed from front to table: up to 8 chars for word
   // compare are included in the full name
   typedef struct packed {
      logic [MaxChars*8-1:0] name;
      logic [5:0]            len;
      logic                  clr_type;
   } tok_type;

   // keyword text, first char in low byte, zero padded
   function automatic logic [63:0] key_word(input int k);
      logic [63:0] w;
      begin
         unique case (k)
            0: w = 64'h0000_0000_0074_6e69;  // int
            1: w = 64'h0000_0074_616f_6c66;  // float
            2: w = 64'h0000_0000_7261_6863;  // char
            3: w = 64'h0000_656c_6275_6f64;  // double
            4: w = 64'h0000_0000_6c6f_6f62;  // bool
            5: w = 64'h0000_0000_6469_6f76;  // void
            6: w = 64'h0000_6e72_6574_7865;  // extern
            7: w = 64'h0000_0000_6f74_7561;  // auto
            8: w = 64'h0000_0000_6c6f_6f62;  // bool
            9: w = 64'h0000_0000_6f74_6f67;  // goto
            10: w = 64'h0000_6369_7461_7473; // static
            11: w = 64'h0000_0073_7361_6c63; // class
            12: w = 64'h0000_7463_7572_7473; // struct
            13: w = 64'h0000_0000_0072_6f66; // for
            14: w = 64'h0000_0000_0000_6669; // if
            15: w = 64'h0000_0000_6573_6c65; // else
            16: w = 64'h0000_6e72_7574_6572; // return
            17: w = 64'h7265_7473_6967_6572; // register
            18: w = 64'h0000_0000_676e_6f6c; // long
            19: w = 64'h0000_0065_6c69_6877; // while
            20: w = 64'h0000_0000_0000_6f64; // do
            default: w = '0;
         endcase
         return w;
      end
   endfunction

   function automatic logic [3:0] key_len(input int k);
      logic [3:0] n;
      begin
         unique case (k)
            0, 13: n = 4'd3;
            1, 11, 19: n = 4'd5;
            2, 4, 5, 7, 8, 9, 15, 18: n = 4'd4;
            3, 6, 10, 12, 16: n = 4'd6;
            14, 20: n = 4'd2;
            17: n = 4'd8;
            default: n = 4'd0;
         endcase
         return n;
      end
   endfunction

   function automatic logic [63:0] ign_word(input int k);
      logic [63:0] w;
      begin
         unique case (k)
            0: w = 64'h0065_6475_6c63_6e69; // include
            1: w = 64'h0000_656e_6966_6564; // define
            2: w = 64'h0000_0068_6374_6567; // getch
            3: w = 64'h0000_6674_6e69_7270; // printf
            4: w = 64'h0000_0066_6e61_6373; // scanf
            default: w = '0;
         endcase
         return w;
      end
   endfunction

   function automatic logic [3:0] ign_len(input int k);
      logic [3:0] n;
      begin
         unique case (k)
            0: n = 4'd7;
            1, 3: n = 4'd6;
            default: n = 4'd5;
         endcase
         return n;
      end
   endfunction

endpackage

// ----- rtl/ists_front.sv -----
// front part: skip tracking and token assembly, one character per transfer
// depends on ists_pkg and the assertion macro header
`include "identifier_symbol_table_scanner_top_macros.svh"
module ists_front
   import ists_pkg::*;
#(
   parameter int TOKEN_CHARS = 11
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_char,
   output logic          tok_valid,
   input  logic          tok_ready,
   output tok_type       tok_data
);

   localparam int LW = $clog2(TOKEN_CHARS + 1);

   logic [1:0]              skip_ff, skip_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [TOKEN_CHARS*8-1:0] chars_ff, chars_in;
   logic                    is_letter, is_delim, ends, do_take;

   // character classes
   always_comb begin
      is_letter = (in_char >= 8'h41 && in_char <= 8'h5a) ||
                  (in_char >= 8'h61 && in_char <= 8'h7a) || in_char == CH_USCORE;
      is_delim = in_char == 8'h20 || in_char == 8'h09 || in_char == 8'h0a ||
                 in_char == 8'h2c || in_char == 8'h29 || in_char == 8'h5b ||
                 in_char == 8'h5d || in_char == 8'h7b || in_char == 8'h7d ||
                 in_char == 8'h23 || in_char == 8'h2b || in_char == 8'h2d ||
                 in_char == 8'h2a || in_char == 8'h2f || in_char == 8'h25 ||
                 in_char == 8'h3d || in_char == 8'h21 || in_char == CH_LPAR ||
                 in_char == CH_SEMI;
   end

   // a token end or type clear needs room in the queue
   assign ends = (skip_ff != SKIP_QUOTE) && (skip_ff != SKIP_ANGLE) && is_delim &&
                 (len_ff != '0 || in_char == CH_SEMI || in_char == CH_LPAR);
   assign in_ready = !ends || tok_ready;
   assign do_take = in_valid && in_ready;
   assign tok_valid = in_valid && ends;

   // only bytes inside the token are passed on, the tail reads as zero
   always_comb begin
      tok_data = '0;
      for (int i = 0; i < TOKEN_CHARS; i++)
         if (LW'(i) < len_ff) tok_data.name[i*8 +: 8] = chars_ff[i*8 +: 8];
      tok_data.len = 6'(len_ff);
      tok_data.clr_type = in_char == CH_SEMI || in_char == CH_LPAR;
   end

   // next state
   always_comb begin
      skip_in = skip_ff;
      len_in = len_ff;
      chars_in = chars_ff;
      priority if (skip_ff == SKIP_QUOTE) begin
         if (in_char == CH_QUOTE) skip_in = SKIP_NONE;
      end else if (skip_ff == SKIP_ANGLE) begin
         if (in_char == CH_GT) skip_in = SKIP_NONE;
      end else begin
         skip_in = SKIP_NONE;
         if (in_char == CH_QUOTE) skip_in = SKIP_QUOTE;
         else if (in_char == CH_LT) skip_in = SKIP_ANGLE;
         else if (is_delim) len_in = '0;
         else if (is_letter && len_ff < LW'(TOKEN_CHARS)) begin
            chars_in[len_ff*8 +: 8] = in_char;
            len_in = len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= SKIP_NONE;
         len_ff <= '0;
      end else if (do_take) begin
         skip_ff <= skip_in;
         len_ff <= len_in;
      end
      if (do_take) chars_ff <= chars_in;
   end

   `ISTS_ASSERT_IMP(a_len_bound, 1'b1, len_ff <= LW'(TOKEN_CHARS))
   `ISTS_ASSERT_IMP(a_tok_has_room, tok_valid && !tok_ready, !in_ready)
   `ISTS_ASSERT_NEXT(a_len_clears, tok_valid && tok_ready, len_ff == '0)

endmodule

// ----- rtl/ists_queue.sv -----
// two-entry queue between the front and the table back end
// depends on ists_pkg
module ists_queue
   import ists_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  tok_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output tok_type rd_data
);

   tok_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

endmodule

// ----- rtl/ists_table.sv -----
// back part: word compare, identifier table search and insert
// depends on ists_pkg and the assertion macro header
`include "identifier_symbol_table_scanner_top_macros.svh"
module ists_table
   import ists_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int TOKEN_CHARS = 11
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       tok_valid,
   output logic       tok_ready,
   input  tok_type    tok_data,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [2:0] out_event,
   output logic [4:0] out_slot,
   output logic [4:0] out_type
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int LW = $clog2(TOKEN_CHARS + 1);
   localparam int NB = TOKEN_CHARS * 8;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [NB-1:0]  name_mem [TABLE_ENTRIES];
   logic [LW-1:0]  len_mem  [TABLE_ENTRIES];
   logic [4:0]     typ_mem  [TABLE_ENTRIES];

   logic [1:0]     st_ff;
   logic [CW-1:0]  cnt_ff;
   logic [CW-1:0]  idx_ff;
   logic [4:0]     cur_ff;
   logic [NB-1:0]  tname_ff;
   logic [LW-1:0]  tlen_ff;
   logic           tclr_ff;
   logic           found_ff;
   logic [IW-1:0]  fslot_ff;
   logic [NB-1:0]  rd_name_ff;
   logic [LW-1:0]  rd_len_ff;
   logic [4:0]     rd_typ_ff;
   logic           rd_ok_ff;
   logic [IW-1:0]  rd_idx_ff;
   logic           ov_ff;
   logic [2:0]     ev_ff;
   logic [4:0]     slot_ff, otyp_ff;

   logic           ign_hit, key_hit;
   logic [4:0]     key_idx;
   logic           name_eq;
   logic           take;

   assign take = tok_valid && tok_ready;
   assign tok_ready = st_ff == ST_IDLE && !ov_ff;
   assign out_valid = ov_ff;
   assign out_event = ev_ff;
   assign out_slot = slot_ff;
   assign out_type = otyp_ff;

   // fixed word compare on the incoming token
   always_comb begin
      ign_hit = 1'b0;
      key_hit = 1'b0;
      key_idx = 5'd0;
      for (int k = 0; k < IgnCount; k++)
         if (tok_data.len == 6'(ign_len(k)) &&
             tok_data.name[63:0] == ign_word(k)) ign_hit = 1'b1;
      for (int k = KeyCount - 1; k >= 0; k--)
         if (tok_data.len == 6'(key_len(k)) &&
             tok_data.name[63:0] == key_word(k)) begin
            key_hit = 1'b1;
            key_idx = 5'(k);
         end
   end

   // compare of the entry read last cycle; tail bytes are zero in both
   assign name_eq = rd_len_ff == tlen_ff && rd_name_ff == tname_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         cnt_ff <= '0;
         cur_ff <= NoType;
         ov_ff <= 1'b0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         unique case (st_ff)
            ST_IDLE: begin
               if (take) begin
                  if (tok_data.len == '0) begin
                     cur_ff <= NoType;
                  end else if (ign_hit) begin
                     ov_ff <= 1'b1;
                     ev_ff <= EV_IGNORED;
                     slot_ff <= 5'd0;
                     otyp_ff <= cur_ff;
                     if (tok_data.clr_type) cur_ff <= NoType;
                  end else if (key_hit) begin
                     ov_ff <= 1'b1;
                     ev_ff <= EV_KEYWORD;
                     slot_ff <= 5'd0;
                     otyp_ff <= key_idx;
                     cur_ff <= tok_data.clr_type ? NoType : key_idx;
                  end else begin
                     st_ff <= ST_SCAN;
                     idx_ff <= '0;
                     found_ff <= 1'b0;
                     rd_ok_ff <= 1'b0;
                  end
               end
            end
            ST_SCAN: begin
               // pipelined read then compare, one entry per cycle
               rd_ok_ff <= idx_ff < cnt_ff;
               rd_idx_ff <= IW'(idx_ff);
               if (idx_ff < cnt_ff) idx_ff <= idx_ff + 1'b1;
               if (rd_ok_ff && name_eq) begin
                  if (rd_typ_ff == cur_ff || cur_ff != NoType) begin
                     ov_ff <= 1'b1;
                     ev_ff <= (rd_typ_ff == cur_ff) ? EV_REDECL : EV_MULTI;
                     slot_ff <= 5'(rd_idx_ff);
                     otyp_ff <= cur_ff;
                     st_ff <= ST_DONE;
                  end else if (!found_ff) begin
                     found_ff <= 1'b1;
                     fslot_ff <= rd_idx_ff;
                  end
               end else if (!rd_ok_ff && idx_ff >= cnt_ff && idx_ff != '0 ||
                            !rd_ok_ff && cnt_ff == '0) begin
                  // scan finished without a decisive match
                  ov_ff <= 1'b1;
                  otyp_ff <= cur_ff;
                  st_ff <= ST_DONE;
                  if (cur_ff == NoType) begin
                     ev_ff <= found_ff ? EV_USE : EV_UNDECL;
                     slot_ff <= found_ff ? 5'(fslot_ff) : 5'd0;
                  end else if (cnt_ff >= CW'(TABLE_ENTRIES)) begin
                     ev_ff <= EV_FULL;
                     slot_ff <= 5'd0;
                  end else begin
                     ev_ff <= EV_INSERT;
                     slot_ff <= 5'(cnt_ff);
                     cnt_ff <= cnt_ff + 1'b1;
                  end
               end
            end
            ST_DONE: begin
               rd_ok_ff <= 1'b0;
               if (tclr_ff) cur_ff <= NoType;
               st_ff <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // token hold, table read port and insert write
   always_ff @(posedge clock) begin
      if (take) begin
         tname_ff <= tok_data.name[NB-1:0];
         tlen_ff <= LW'(tok_data.len);
         tclr_ff <= tok_data.clr_type;
      end
      rd_name_ff <= name_mem[IW'(idx_ff)];
      rd_len_ff <= len_mem[IW'(idx_ff)];
      rd_typ_ff <= typ_mem[IW'(idx_ff)];
      if (!reset && st_ff == ST_SCAN && !(rd_ok_ff && name_eq) && !rd_ok_ff &&
          cur_ff != NoType && cnt_ff < CW'(TABLE_ENTRIES) &&
          (idx_ff >= cnt_ff && idx_ff != '0 || cnt_ff == '0)) begin
         name_mem[IW'(cnt_ff)] <= tname_ff;
         len_mem[IW'(cnt_ff)] <= tlen_ff;
         typ_mem[IW'(cnt_ff)] <= cur_ff;
      end
   end

   `ISTS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CW'(TABLE_ENTRIES))
   `ISTS_ASSERT_IMP(a_busy_no_take, st_ff != ST_IDLE, !tok_ready)
   `ISTS_ASSERT_NEXT(a_done_idle, st_ff == ST_DONE, st_ff == ST_IDLE)

endmodule

// ----- rtl/identifier_symbol_table_scanner_top.sv -----
// a keyword or ignored word result is registered straight from the idle state,
// while an identifier result follows a linear table scan that reads one entry per cycle
// from the single table read port
// throughput: one character per cycle between tokens while the queue has room; the back end
// takes a new token only once the previous result has left, behind a two-entry queue
// synchronous reset empties the token, the table and clears the current type
module identifier_symbol_table_scanner_top
   import ists_pkg::*;
#(
   parameter int TABLE_ENTRIES = 32,
   parameter int TOKEN_CHARS = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] event_res, [7:3] slot, [12:8] type_code
);

   logic    f_valid, f_ready, b_valid, b_ready;
   tok_type f_data, b_data;
   logic [2:0] ev;
   logic [4:0] sl, ty;

   ists_front #(.TOKEN_CHARS(TOKEN_CHARS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata), .tok_valid(f_valid), .tok_ready(f_ready), .tok_data(f_data)
   );

   ists_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
   );

   ists_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .TOKEN_CHARS(TOKEN_CHARS)) u_table (
      .clock, .reset, .tok_valid(b_valid), .tok_ready(b_ready), .tok_data(b_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_event(ev),
      .out_slot(sl), .out_type(ty)
   );

   assign rsp_tdata = {3'b000, ty, sl, ev};

endmodule
